[hw/rtl/pdcs_pkg.sv]
package pdcs_pkg;

    typedef struct packed {
        logic start;
        logic mod_start;
        logic mod_load_euclid;
    } pdcs_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic rem_zero;
        logic b_zero;
        logic gcd_one;
        logic digit_done;
        logic any_zero;
    } pdcs_status_t;

    // modulo operand order
    localparam logic [1:0] MOD_A_BY_B = 2'd0;
    localparam logic [1:0] MOD_B_BY_A = 2'd1;

    localparam int SUM_OUT_WIDTH = 7;
    localparam int OUT_COUNT_WIDTH = 32;

endpackage

[hw/rtl/pdcs_datapath.sv]
module pdcs_datapath
    import pdcs_pkg::*;
#(
    parameter int VALUE_WIDTH = 31
)
(
    input  logic                   clk,
    input  logic [VALUE_WIDTH-1:0] first_number,
    input  logic [VALUE_WIDTH-1:0] second_number,
    input  pdcs_cmd_t              cmd,
    input  logic [1:0]             mod_sel,
    output pdcs_status_t           status,
    output logic [SUM_OUT_WIDTH-1:0] first_digit_sum,
    output logic [SUM_OUT_WIDTH-1:0] second_digit_sum,
    output logic                   sums_equal
);
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int ND = (VALUE_WIDTH * 31) / 100 + 2;
    localparam int BW = 4 * ND;
    localparam int SW = $clog2(9 * ND + 1);

    logic [VALUE_WIDTH-1:0] a_reg, b_reg, num_reg, den_reg, rem_reg;
    logic [VALUE_WIDTH-1:0] da_reg, db_reg;
    logic [BW-1:0]          bcd_a_reg, bcd_b_reg;
    logic [CW-1:0]          conv_reg;
    logic [SW-1:0]          sa_reg, sb_reg;
    logic [CW-1:0]          bit_reg;
    logic                   mod_busy_reg, mod_done_reg;

    // restoring divide, one quotient bit per cycle
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] rem_shift;
    always_comb
    begin
        rem_shift = {rem_reg[VALUE_WIDTH-2:0], num_reg[VALUE_WIDTH-1]};
        trial = {rem_reg[VALUE_WIDTH-1], rem_shift} - {1'b0, den_reg};
    end

    // double dabble step: add 3 to digits above 4, then shift in one bit
    function automatic logic [BW-1:0] dabble(input logic [BW-1:0] bcd, input logic in_bit);
        logic [BW-1:0] adj;
        adj = bcd;
        for (int i = 0; i < ND; i++)
        begin
            if (adj[4*i +: 4] > 4'd4)
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
        end
        return {adj[BW-2:0], in_bit};
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg     <= first_number;
            b_reg     <= second_number;
            da_reg    <= first_number;
            db_reg    <= second_number;
            bcd_a_reg <= '0;
            bcd_b_reg <= '0;
            conv_reg  <= CW'(VALUE_WIDTH);
            sa_reg    <= '0;
            sb_reg    <= '0;
        end
        else if (conv_reg != '0)
        begin
            // binary to bcd, msb first
            bcd_a_reg <= dabble(bcd_a_reg, da_reg[VALUE_WIDTH-1]);
            bcd_b_reg <= dabble(bcd_b_reg, db_reg[VALUE_WIDTH-1]);
            da_reg    <= {da_reg[VALUE_WIDTH-2:0], 1'b0};
            db_reg    <= {db_reg[VALUE_WIDTH-2:0], 1'b0};
            conv_reg  <= conv_reg - CW'(1);
        end
        else if (bcd_a_reg != '0 || bcd_b_reg != '0)
        begin
            // accumulate one decimal digit per cycle
            bcd_a_reg <= bcd_a_reg >> 4;
            bcd_b_reg <= bcd_b_reg >> 4;
            sa_reg    <= sa_reg + SW'(bcd_a_reg[3:0]);
            sb_reg    <= sb_reg + SW'(bcd_b_reg[3:0]);
        end
        mod_done_reg <= 1'b0;
        if (cmd.mod_start)
        begin
            case (mod_sel)
                MOD_A_BY_B: begin num_reg <= a_reg; den_reg <= b_reg; end
                MOD_B_BY_A: begin num_reg <= b_reg; den_reg <= a_reg; end
                default:    begin num_reg <= a_reg; den_reg <= b_reg; end
            endcase
            rem_reg <= '0;
            bit_reg <= CW'(VALUE_WIDTH);
            mod_busy_reg <= 1'b1;
        end
        else if (mod_busy_reg)
        begin
            num_reg <= {num_reg[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
            rem_reg <= trial[VALUE_WIDTH] ? rem_shift : trial[VALUE_WIDTH-1:0];
            bit_reg <= bit_reg - CW'(1);
            if (bit_reg == CW'(1))
            begin
                mod_busy_reg <= 1'b0;
                mod_done_reg <= 1'b1;
            end
        end
        if (cmd.mod_load_euclid)
        begin
            // a <- b, b <- a mod b
            a_reg <= b_reg;
            b_reg <= rem_reg;
        end
    end

    always_comb
    begin
        status.mod_done   = mod_done_reg;
        status.rem_zero   = (rem_reg == '0);
        status.b_zero     = (b_reg == '0);
        status.gcd_one    = (a_reg == VALUE_WIDTH'(1));
        status.digit_done = (conv_reg == '0) && (bcd_a_reg == '0) && (bcd_b_reg == '0)
                         && !cmd.start;
        status.any_zero   = (a_reg == '0) || (b_reg == '0);
        first_digit_sum   = (sa_reg > SW'(127)) ? 7'd127 : SUM_OUT_WIDTH'(sa_reg);
        second_digit_sum  = (sb_reg > SW'(127)) ? 7'd127 : SUM_OUT_WIDTH'(sb_reg);
        sums_equal        = (sa_reg == sb_reg);
    end
endmodule

[hw/rtl/pdcs_control.sv]
module pdcs_control
    import pdcs_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  pdcs_status_t status,
    input  logic         sums_equal,
    output pdcs_cmd_t    cmd,
    output logic [1:0]   mod_sel,
    output logic         divides_either,
    output logic         is_coprime,
    output logic         equal_digit_sum,
    output logic         operand_zero,
    output logic [OUT_COUNT_WIDTH-1:0] count_divides,
    output logic [OUT_COUNT_WIDTH-1:0] count_coprime,
    output logic [OUT_COUNT_WIDTH-1:0] count_digit_sum
);
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_DIV_AB, S_DIV_BA, S_GCD_START, S_GCD_WAIT, S_DIGITS, S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0] mod_sel_reg;
    logic div_reg, cop_reg, zero_reg, eq_reg, ov_reg;
    logic [COUNT_WIDTH-1:0] cd_reg, cc_reg, ce_reg;
    logic [COUNT_WIDTH-1:0] cd_next, cc_next, ce_next;

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign mod_sel   = mod_sel_reg;
    always_comb
    begin
        cmd.start           = (state_reg == S_IDLE) && in_valid;
        cmd.mod_start       = (state_reg == S_CHECK && !status.any_zero)
                           || (state_reg == S_DIV_AB && status.mod_done && !status.rem_zero)
                           || (state_reg == S_GCD_START && !status.b_zero);
        cmd.mod_load_euclid = (state_reg == S_GCD_WAIT) && status.mod_done;
        cd_next = cd_reg + COUNT_WIDTH'(div_reg && cd_reg != CMAX);
        cc_next = cc_reg + COUNT_WIDTH'(cop_reg && cc_reg != CMAX);
        ce_next = ce_reg + COUNT_WIDTH'(sums_equal && ce_reg != CMAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            mod_sel_reg <= MOD_A_BY_B;
            cd_reg <= '0; cc_reg <= '0; ce_reg <= '0;
            div_reg <= 1'b0; cop_reg <= 1'b0; zero_reg <= 1'b0; eq_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_CHECK;
                        div_reg <= 1'b0; cop_reg <= 1'b0;
                        mod_sel_reg <= MOD_A_BY_B;
                    end
                S_CHECK:
                begin
                    zero_reg <= status.any_zero;
                    state_reg <= status.any_zero ? S_DIGITS : S_DIV_AB;
                end
                S_DIV_AB:
                    if (status.mod_done)
                    begin
                        if (status.rem_zero)
                        begin
                            div_reg <= 1'b1;
                            mod_sel_reg <= MOD_A_BY_B;
                            state_reg <= S_GCD_START;
                        end
                        else
                        begin
                            mod_sel_reg <= MOD_A_BY_B;
                            state_reg <= S_DIV_BA;
                        end
                    end
                    else if (state_reg == S_DIV_AB)
                        mod_sel_reg <= MOD_B_BY_A;
                S_DIV_BA:
                    if (status.mod_done)
                    begin
                        div_reg <= status.rem_zero;
                        state_reg <= S_GCD_START;
                    end
                S_GCD_START:
                    if (status.b_zero)
                    begin
                        cop_reg <= status.gcd_one;
                        state_reg <= S_DIGITS;
                    end
                    else
                        state_reg <= S_GCD_WAIT;
                S_GCD_WAIT:
                    if (status.mod_done)
                        state_reg <= S_GCD_START;
                S_DIGITS:
                    if (status.digit_done)
                    begin
                        eq_reg <= sums_equal && !zero_reg;
                        if (!zero_reg)
                        begin
                            cd_reg <= cd_next;
                            cc_reg <= cc_next;
                            if (sums_equal) ce_reg <= ce_next;
                        end
                        ov_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                S_OUT:
                    if (!out_stall)
                    begin
                        ov_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign divides_either  = div_reg;
    assign is_coprime      = cop_reg;
    assign equal_digit_sum = eq_reg;
    assign operand_zero    = zero_reg;
    assign count_divides   = OUT_COUNT_WIDTH'(cd_reg);
    assign count_coprime   = OUT_COUNT_WIDTH'(cc_reg);
    assign count_digit_sum = OUT_COUNT_WIDTH'(ce_reg);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count_divides))
        else $error("result changed under stall");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted with result pending");
    a_zero_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && operand_zero |-> !divides_either && !is_coprime && !equal_digit_sum)
        else $error("flags set on zero operand");
endmodule

[hw/rtl/pair_divisibility_coprime_stats.sv]
// channel | handshake             | payload
// in      | in_valid / in_stall   | first_number, second_number
// out     | out_valid / out_stall | flags, digit sums, counts
//
// sequential: one pair at a time through a shared bit-serial modulo unit
// one modulo per bit-serial run; b mod a runs only when a mod b is nonzero
// euclid step is one modulo, then a <- b, b <- remainder; up to ~45 steps for 31-bit operands
// transaction = accept, zero check, modulos, euclid steps, digit sums, output, plus any out_stall time
// digit sums run alongside: binary to bcd conversion, then one digit per cycle
// rst_n async clears counters and control; output holds while stalled
module pair_divisibility_coprime_stats
    import pdcs_pkg::*;
#(
    parameter int VALUE_WIDTH = 31,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] first_number,
    input  logic [VALUE_WIDTH-1:0] second_number,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   divides_either,
    output logic                   is_coprime,
    output logic                   equal_digit_sum,
    output logic                   operand_zero,
    output logic [6:0]             first_digit_sum,
    output logic [6:0]             second_digit_sum,
    output logic [31:0]            count_divides,
    output logic [31:0]            count_coprime,
    output logic [31:0]            count_digit_sum
);
    pdcs_cmd_t    cmd;
    pdcs_status_t status;
    logic [1:0]   mod_sel;
    logic         sums_equal;

    // datapath: divider, euclid registers, digit extraction
    pdcs_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk(clk), .first_number(first_number), .second_number(second_number),
        .cmd(cmd), .mod_sel(mod_sel), .status(status),
        .first_digit_sum(first_digit_sum), .second_digit_sum(second_digit_sum),
        .sums_equal(sums_equal)
    );

    // controller: sequencing, flags and saturating counters
    pdcs_control #(.COUNT_WIDTH(COUNT_WIDTH)) u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .sums_equal(sums_equal), .cmd(cmd), .mod_sel(mod_sel),
        .divides_either(divides_either), .is_coprime(is_coprime),
        .equal_digit_sum(equal_digit_sum), .operand_zero(operand_zero),
        .count_divides(count_divides), .count_coprime(count_coprime),
        .count_digit_sum(count_digit_sum)
    );
endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int VW = 31;
    localparam int CYCLE_LIMIT = 10_000_000;

    // one expected result transaction
    typedef struct {
        logic        divides;
        logic        coprime;
        logic        same_sum;
        logic        zero;
        logic [6:0]  sum_a;
        logic [6:0]  sum_b;
        logic [31:0] cnt_div;
        logic [31:0] cnt_cop;
        logic [31:0] cnt_sum;
    } pair_stats_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [VW-1:0] first_number;
    logic [VW-1:0] second_number;
    logic          out_valid;
    logic          out_stall;
    logic          divides_either;
    logic          is_coprime;
    logic          equal_digit_sum;
    logic          operand_zero;
    logic [6:0]    first_digit_sum;
    logic [6:0]    second_digit_sum;
    logic [31:0]   count_divides;
    logic [31:0]   count_coprime;
    logic [31:0]   count_digit_sum;

    // predictor copy of the three running counters
    logic [31:0] divides_tally;
    logic [31:0] coprime_tally;
    logic [31:0] digit_sum_tally;

    pair_stats_t expected_stats[$];
    int          error_count;
    int          cycle_count = 0;
    bit          hold_off;      // long receiver stall requested

    pair_divisibility_coprime_stats #(.VALUE_WIDTH(VW), .COUNT_WIDTH(32)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .first_number(first_number),
        .second_number(second_number),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .divides_either(divides_either),
        .is_coprime(is_coprime),
        .equal_digit_sum(equal_digit_sum),
        .operand_zero(operand_zero),
        .first_digit_sum(first_digit_sum),
        .second_digit_sum(second_digit_sum),
        .count_divides(count_divides),
        .count_coprime(count_coprime),
        .count_digit_sum(count_digit_sum)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [6:0] decimal_sum(input logic [VW-1:0] v);
        longint unsigned x;
        int s;
        x = v;
        s = 0;
        while (x != 0)
        begin
            s += int'(x % 10);
            x /= 10;
        end
        return (s > 127) ? 7'd127 : 7'(s);
    endfunction

    function automatic longint unsigned gcd_of(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic logic [31:0] saturating_inc(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // work out flags, digit sums and updated counters for one pair
    function automatic pair_stats_t predict_pair_stats(input logic [VW-1:0] a,
                                                       input logic [VW-1:0] b);
        pair_stats_t r;
        longint unsigned la;
        longint unsigned lb;
        la = a;
        lb = b;
        r.sum_a = decimal_sum(a);
        r.sum_b = decimal_sum(b);
        r.divides = 1'b0;
        r.coprime = 1'b0;
        r.same_sum = 1'b0;
        r.zero = 1'b0;
        if (la == 0 || lb == 0)
            r.zero = 1'b1;
        else
        begin
            r.divides = (la % lb == 0) || (lb % la == 0);
            r.coprime = (gcd_of(la, lb) == 1);
            // sums never exceed 127 at this width, so clipped compare is exact
            r.same_sum = (r.sum_a == r.sum_b);
            if (r.divides) divides_tally = saturating_inc(divides_tally);
            if (r.coprime) coprime_tally = saturating_inc(coprime_tally);
            if (r.same_sum) digit_sum_tally = saturating_inc(digit_sum_tally);
        end
        r.cnt_div = divides_tally;
        r.cnt_cop = coprime_tally;
        r.cnt_sum = digit_sum_tally;
        return r;
    endfunction

    // send one pair; inputs move on the falling edge, accept seen at rising
    task automatic send_pair(input logic [VW-1:0] a, input logic [VW-1:0] b);
        in_valid <= 1'b1;
        first_number <= a;
        second_number <= b;
        do
            @(posedge clk);
        while (in_stall);
        expected_stats.push_back(predict_pair_stats(a, b));
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // burst sender: drops valid only between bursts, never mid-burst
    task automatic send_burst(input logic [VW-1:0] a, input logic [VW-1:0] b,
                              input bit last_in_burst);
        in_valid <= 1'b1;
        first_number <= a;
        second_number <= b;
        do
            @(posedge clk);
        while (in_stall);
        expected_stats.push_back(predict_pair_stats(a, b));
        @(negedge clk);
        if (last_in_burst)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    function automatic logic [VW-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return VW'($urandom_range(1, 20));
            1: return VW'($urandom_range(1, 1000));
            2: return VW'({$urandom} >> $urandom_range(1, 30));
            3: return VW'({$urandom});
            4: return {VW{1'b1}};
            default: return VW'($urandom_range(1, 100000));
        endcase
    endfunction

    // extremes, zero operands, divisible, coprime and equal-sum pairs
    task automatic test_directed();
        send_pair('0, '0);
        send_pair('0, VW'(5));
        send_pair(VW'(7), '0);
        send_pair(VW'(1), VW'(1));
        send_pair({VW{1'b1}}, {VW{1'b1}});
        send_pair({VW{1'b1}}, VW'(1));
        send_pair(VW'(1), {VW{1'b1}});
        send_pair(VW'(12), VW'(36));
        send_pair(VW'(36), VW'(12));
        send_pair(VW'(35), VW'(64));
        send_pair(VW'(19), VW'(91));
        send_pair(VW'(1999999999), VW'(1999999998));
        send_pair(VW'(1836311903), VW'(1134903170));
        send_pair(VW'(10), VW'(100));
        send_pair(VW'(1073741824), VW'(2));
        send_pair(VW'(1431655765), VW'(715827882));
        send_pair(VW'(123), VW'(321));
        send_pair(VW'(999999999), VW'(1999999999));
    endtask

    // random pairs in bursts, some multiples, a few zeros
    task automatic test_random(input int n);
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        int k;
        for (int i = 0; i < n; i++)
        begin
            a = random_value();
            b = random_value();
            k = $urandom_range(0, 19);
            if (k < 3)
                b = VW'(a * $urandom_range(1, 9));
            else if (k == 3)
                a = '0;
            else if (k == 4)
                b = '0;
            send_burst(a, b, ($urandom_range(0, 5) == 0) || (i == n - 1));
        end
    endtask

    // receiver holds off long while sender keeps offering pairs
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(8);
            begin
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
        join
    endtask

    // receiver stall pattern
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if ((cycle_count / 200) % 3 == 0)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // checker on each output transaction
    always @(posedge clk)
    begin
        pair_stats_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_stats.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result transaction", $time);
            end
            else
            begin
                e = expected_stats.pop_front();
                if (divides_either !== e.divides)
                begin
                    error_count++;
                    $display("%0t: divides_either exp %0b got %0b", $time,
                             e.divides, divides_either);
                end
                if (is_coprime !== e.coprime)
                begin
                    error_count++;
                    $display("%0t: is_coprime exp %0b got %0b", $time,
                             e.coprime, is_coprime);
                end
                if (equal_digit_sum !== e.same_sum)
                begin
                    error_count++;
                    $display("%0t: equal_digit_sum exp %0b got %0b", $time,
                             e.same_sum, equal_digit_sum);
                end
                if (operand_zero !== e.zero)
                begin
                    error_count++;
                    $display("%0t: operand_zero exp %0b got %0b", $time,
                             e.zero, operand_zero);
                end
                if (first_digit_sum !== e.sum_a)
                begin
                    error_count++;
                    $display("%0t: first_digit_sum exp %0d got %0d", $time,
                             e.sum_a, first_digit_sum);
                end
                if (second_digit_sum !== e.sum_b)
                begin
                    error_count++;
                    $display("%0t: second_digit_sum exp %0d got %0d", $time,
                             e.sum_b, second_digit_sum);
                end
                if (count_divides !== e.cnt_div)
                begin
                    error_count++;
                    $display("%0t: count_divides exp %0d got %0d", $time,
                             e.cnt_div, count_divides);
                end
                if (count_coprime !== e.cnt_cop)
                begin
                    error_count++;
                    $display("%0t: count_coprime exp %0d got %0d", $time,
                             e.cnt_cop, count_coprime);
                end
                if (count_digit_sum !== e.cnt_sum)
                begin
                    error_count++;
                    $display("%0t: count_digit_sum exp %0d got %0d", $time,
                             e.cnt_sum, count_digit_sum);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        first_number = '0;
        second_number = '0;
        divides_tally = '0;
        coprime_tally = '0;
        digit_sum_tally = '0;
        error_count = 0;
        hold_off = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random(1230);

        // drain outstanding results, then allow some slack
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hw/rtl/pdcs_pkg.sv
hw/rtl/pdcs_datapath.sv
hw/rtl/pdcs_control.sv
hw/rtl/pair_divisibility_coprime_stats.sv
verif/testbench.sv
